### design/http_request_line_parser_macros.svh
// Assertion macros shared by the request line parser.
// Every macro samples on the rising edge of clock.
`ifndef HTTP_REQUEST_LINE_PARSER_MACROS_SVH
`define HTTP_REQUEST_LINE_PARSER_MACROS_SVH

// The property is checked at every edge except while reset is high.
`define HRLP_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// The property is checked at every edge, reset included.
`define HRLP_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

### design/hrlp_pkg.sv
// Types, byte codes, tag codes and error codes of the request line parser.
// It depends on nothing and is used by the top level.
`default_nettype none

package hrlp_pkg;

   typedef enum logic [5:0] {
      PHASE_SKIP    = 6'b000001,
      PHASE_METHOD  = 6'b000010,
      PHASE_TARGET  = 6'b000100,
      PHASE_VERSION = 6'b001000,
      PHASE_DONE    = 6'b010000,
      PHASE_ERROR   = 6'b100000
   } phase_type;

   localparam logic [7:0] CHAR_SPACE    = 8'h20;
   localparam logic [7:0] CHAR_LF       = 8'h0a;
   localparam logic [7:0] CHAR_CR       = 8'h0d;
   localparam logic [7:0] CHAR_QUESTION = 8'h3f;

   localparam int VERSION_LEN = 7;

   localparam logic [2:0] CLASS_SKIPPED   = 3'd0;
   localparam logic [2:0] CLASS_METHOD    = 3'd1;
   localparam logic [2:0] CLASS_SEPARATOR = 3'd2;
   localparam logic [2:0] CLASS_PATH      = 3'd3;
   localparam logic [2:0] CLASS_QUERY     = 3'd4;
   localparam logic [2:0] CLASS_VERSION   = 3'd5;
   localparam logic [2:0] CLASS_LINE_END  = 3'd6;
   localparam logic [2:0] CLASS_BEYOND    = 3'd7;

   localparam logic [1:0] ERROR_NONE        = 2'd0;
   localparam logic [1:0] ERROR_SPACES      = 2'd1;
   localparam logic [1:0] ERROR_LINE_END    = 2'd2;
   localparam logic [1:0] ERROR_VERSION     = 2'd3;

   // Expected characters of the version prefix "HTTP/1.".
   function automatic logic [7:0] version_char(input logic [2:0] idx);
      logic [7:0] c;
      unique case (idx)
         3'd0: c = 8'h48;
         3'd1: c = 8'h54;
         3'd2: c = 8'h54;
         3'd3: c = 8'h50;
         3'd4: c = 8'h2f;
         3'd5: c = 8'h31;
         3'd6: c = 8'h2e;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

endpackage

`default_nettype wire

### design/http_request_line_parser.sv
// Request line parser: tags each byte of an HTTP request with its part of the line.
// It depends on hrlp_pkg and on http_request_line_parser_macros.svh.
//
// Usage:
//    The request channel (req_valid, req_ready, req_data_byte) carries one byte of the
//    request stream per transfer. The response channel (rsp_valid, rsp_ready and the
//    rsp_ payload) returns one tagged byte per request byte, in order.
//    Each response carries the byte unchanged, its class, the sticky accepted flag
//    and the sticky error code as they stand after that byte.
//    A byte taken at a clock edge is registered and shown as a response after that edge.
//    Throughput is one byte per cycle while the receiver takes each response; the
//    parser state is updated by one short pass of logic from the byte and the state
//    into the response register. When the receiver stalls, the response register
//    holds its transfer and req_ready drops; when the response is taken, a new byte
//    is accepted in the same cycle.
//    Reset clears the response valid flag and returns the parser to skipping leading
//    CR and LF bytes, with no error and no accepted line.
`default_nettype none

`include "http_request_line_parser_macros.svh"

module http_request_line_parser (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_byte_echo,
   output logic [2:0]      rsp_byte_class,
   output logic            rsp_line_accepted,
   output logic [1:0]      rsp_error_code
);

   hrlp_pkg::phase_type phase_ff, phase_in, cur_phase;
   logic       in_query_ff, in_query_in;
   logic [2:0] version_count_ff, version_count_in;
   logic       version_match_ff, version_match_in;
   logic       previous_was_cr_ff;
   logic [1:0] error_ff, error_in;
   logic       accepted_ff, accepted_in;
   logic [2:0] byte_class;
   logic       is_blank;
   logic       accept;

   logic       rsp_valid_ff;
   logic [7:0] rsp_byte_ff;
   logic [2:0] rsp_class_ff;
   logic       rsp_accepted_ff;
   logic [1:0] rsp_error_ff;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;

   assign is_blank  = (req_data_byte == hrlp_pkg::CHAR_CR) ||
                      (req_data_byte == hrlp_pkg::CHAR_LF);
   assign cur_phase = (phase_ff == hrlp_pkg::PHASE_SKIP) ? hrlp_pkg::PHASE_METHOD : phase_ff;

   always_comb begin
      phase_in         = phase_ff;
      in_query_in      = in_query_ff;
      version_count_in = version_count_ff;
      version_match_in = version_match_ff;
      error_in         = error_ff;
      accepted_in      = accepted_ff;
      byte_class       = hrlp_pkg::CLASS_BEYOND;
      if (phase_ff == hrlp_pkg::PHASE_DONE || phase_ff == hrlp_pkg::PHASE_ERROR) begin
         byte_class = hrlp_pkg::CLASS_BEYOND;
      end else if (phase_ff == hrlp_pkg::PHASE_SKIP && is_blank) begin
         byte_class = hrlp_pkg::CLASS_SKIPPED;
      end else begin
         phase_in = cur_phase;
         priority if (req_data_byte == hrlp_pkg::CHAR_SPACE) begin
            if (cur_phase == hrlp_pkg::PHASE_METHOD) begin
               phase_in   = hrlp_pkg::PHASE_TARGET;
               byte_class = hrlp_pkg::CLASS_SEPARATOR;
            end else if (cur_phase == hrlp_pkg::PHASE_TARGET) begin
               phase_in   = hrlp_pkg::PHASE_VERSION;
               byte_class = hrlp_pkg::CLASS_SEPARATOR;
            end else begin
               phase_in = hrlp_pkg::PHASE_ERROR;
               error_in = hrlp_pkg::ERROR_SPACES;
            end
         end else if (req_data_byte == hrlp_pkg::CHAR_LF) begin
            if (!previous_was_cr_ff || cur_phase != hrlp_pkg::PHASE_VERSION) begin
               phase_in = hrlp_pkg::PHASE_ERROR;
               error_in = hrlp_pkg::ERROR_LINE_END;
            end else if (version_count_ff < 3'(hrlp_pkg::VERSION_LEN) ||
                         !version_match_ff) begin
               phase_in = hrlp_pkg::PHASE_ERROR;
               error_in = hrlp_pkg::ERROR_VERSION;
            end else begin
               phase_in    = hrlp_pkg::PHASE_DONE;
               accepted_in = 1'b1;
               byte_class  = hrlp_pkg::CLASS_LINE_END;
            end
         end else if (cur_phase == hrlp_pkg::PHASE_METHOD) begin
            byte_class = hrlp_pkg::CLASS_METHOD;
         end else if (cur_phase == hrlp_pkg::PHASE_TARGET) begin
            if (in_query_ff) begin
               byte_class = hrlp_pkg::CLASS_QUERY;
            end else if (req_data_byte == hrlp_pkg::CHAR_QUESTION) begin
               in_query_in = 1'b1;
               byte_class  = hrlp_pkg::CLASS_SEPARATOR;
            end else begin
               byte_class = hrlp_pkg::CLASS_PATH;
            end
         end else begin
            if (version_count_ff < 3'(hrlp_pkg::VERSION_LEN)) begin
               if (req_data_byte != hrlp_pkg::version_char(version_count_ff)) begin
                  version_match_in = 1'b0;
               end
               version_count_in = version_count_ff + 3'd1;
            end
            byte_class = hrlp_pkg::CLASS_VERSION;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff           <= hrlp_pkg::PHASE_SKIP;
         in_query_ff        <= 1'b0;
         version_count_ff   <= 3'd0;
         version_match_ff   <= 1'b1;
         previous_was_cr_ff <= 1'b0;
         error_ff           <= hrlp_pkg::ERROR_NONE;
         accepted_ff        <= 1'b0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff           <= phase_in;
            in_query_ff        <= in_query_in;
            version_count_ff   <= version_count_in;
            version_match_ff   <= version_match_in;
            previous_was_cr_ff <= (req_data_byte == hrlp_pkg::CHAR_CR);
            error_ff           <= error_in;
            accepted_ff        <= accepted_in;
            rsp_valid_ff       <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_byte_ff     <= req_data_byte;
         rsp_class_ff    <= byte_class;
         rsp_accepted_ff <= accepted_in;
         rsp_error_ff    <= error_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_byte_echo     = rsp_byte_ff;
   assign rsp_byte_class    = rsp_class_ff;
   assign rsp_line_accepted = rsp_accepted_ff;
   assign rsp_error_code    = rsp_error_ff;

   `HRLP_ASSERT_RST(a_accept_excludes_error, rsp_valid |-> !(rsp_line_accepted && rsp_error_code != hrlp_pkg::ERROR_NONE), "accepted line reported with an error")
   `HRLP_ASSERT_RST(a_accepted_sticky, accepted_ff |=> accepted_ff, "accepted flag cleared without reset")
   `HRLP_ASSERT_RST(a_error_sticky, error_ff != hrlp_pkg::ERROR_NONE |=> error_ff == $past(error_ff), "sticky error changed")
   `HRLP_ASSERT_RST(a_line_end_flag, (rsp_valid && rsp_byte_class == hrlp_pkg::CLASS_LINE_END) |-> rsp_line_accepted, "line end tag without accepted flag")
   `HRLP_ASSERT(a_version_count_phase, version_count_ff != 3'd0 |-> (phase_ff == hrlp_pkg::PHASE_VERSION || phase_ff == hrlp_pkg::PHASE_DONE || phase_ff == hrlp_pkg::PHASE_ERROR), "version bytes counted outside the version")

endmodule

`default_nettype wire
